### hw/rtl/hcbd_pkg.sv
package hcbd_pkg;

    localparam int DEF_MAX_SIZE_DIGITS = 8;
    localparam int DEF_QUEUE_DEPTH     = 4;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef enum logic [2:0] {
        ST_RUN     = 3'd0,
        ST_DONE    = 3'd1,
        ST_BADSIZE = 3'd2,
        ST_NOTERM  = 3'd3,
        ST_SHORT   = 3'd4
    } t_status;

    typedef enum logic [10:0] {
        PH_LEAD          = 11'b000_0000_0001,
        PH_DIGITS        = 11'b000_0000_0010,
        PH_TRAILWS       = 11'b000_0000_0100,
        PH_EXT           = 11'b000_0000_1000,
        PH_DATA          = 11'b000_0001_0000,
        PH_TERM          = 11'b000_0010_0000,
        PH_TERM_CR       = 11'b000_0100_0000,
        PH_ZERO_FIRST    = 11'b000_1000_0000,
        PH_ZERO_FIRST_CR = 11'b001_0000_0000,
        PH_ZERO_SCAN     = 11'b010_0000_0000,
        PH_ZERO_LF       = 11'b100_0000_0000
    } t_phase;

    // Trailer search progress after a zero-size chunk line
    typedef enum logic [1:0] {
        TM_NONE   = 2'd0,
        TM_CR     = 2'd1,
        TM_CRLF   = 2'd2,
        TM_CRLFCR = 2'd3
    } t_trail;

    // One classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_lf;
        logic       is_cr;
        logic       is_space;
        logic       is_semi;
        logic       is_hex;
        logic [3:0] hex_val;
    } t_item;

endpackage

### hw/rtl/hcbd_front.sv
module hcbd_front
    import hcbd_pkg::*;
(
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_is_last,
    input  logic       i_full,
    output logic       o_stall,
    output logic       o_push,
    output t_item      o_item
);

    logic [7:0] w_b;

    assign w_b     = i_data_byte;
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item          = '0;
        o_item.data     = w_b;
        o_item.last     = i_is_last;
        o_item.is_lf    = (w_b == CH_LF);
        o_item.is_cr    = (w_b == CH_CR);
        o_item.is_space = (w_b == CH_SP) || (w_b == CH_TAB) || (w_b == CH_VT) ||
                          (w_b == CH_FF) || (w_b == CH_CR);
        o_item.is_semi  = (w_b == CH_SEMI);
        if (w_b inside {[8'h30:8'h39]}) begin
            o_item.is_hex  = 1'b1;
            o_item.hex_val = w_b[3:0];
        end else if (w_b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            // 'A'..'F' and 'a'..'f' share the low nibble 1..6
            o_item.is_hex  = 1'b1;
            o_item.hex_val = w_b[3:0] + 4'd9;
        end
    end

endmodule

### hw/rtl/hcbd_queue.sv
module hcbd_queue
    import hcbd_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_nempty,
    output t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_pop;

    assign o_full   = (r_count == FULL_CNT);
    assign o_nempty = (r_count != '0);
    assign o_item   = r_mem[r_rd_ptr];
    assign w_pop    = i_pop && o_nempty;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### hw/rtl/hcbd_back.sv
module hcbd_back
    import hcbd_pkg::*;
#(
    parameter int MAX_SIZE_DIGITS = DEF_MAX_SIZE_DIGITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_nempty,
    input  t_item      i_item,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic [2:0] o_status
);

    localparam int CNT_W = $clog2(MAX_SIZE_DIGITS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SIZE_DIGITS);

    t_phase           r_phase, n_phase;
    t_status          r_sticky, n_sticky;
    t_trail           r_tm, n_tm;
    logic [31:0]      r_acc, n_acc;
    logic [31:0]      r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_bad, n_bad;

    logic             r_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_valid, n_out_valid;
    t_status          r_status, n_status;

    logic             w_take;
    logic             w_lf_done;

    assign w_take      = i_nempty && (!r_valid || !i_stall);
    assign o_pop       = w_take;
    assign o_valid     = r_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

    assign w_lf_done = (r_phase == PH_ZERO_LF) || (r_tm == TM_CRLF) || (r_tm == TM_CRLFCR);

    always_comb begin
        n_phase     = r_phase;
        n_sticky    = r_sticky;
        n_tm        = r_tm;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_bad       = r_bad;
        n_out_byte  = 8'h00;
        n_out_valid = 1'b0;

        if (r_sticky == ST_RUN) begin
            case (r_phase)
                PH_LEAD, PH_DIGITS, PH_TRAILWS, PH_EXT: begin
                    if (i_item.is_lf) begin
                        if (r_bad || r_cnt == '0) begin
                            n_sticky = ST_BADSIZE;
                        end else if (r_acc == '0) begin
                            n_phase = PH_ZERO_FIRST;
                        end else begin
                            n_rem   = r_acc;
                            n_phase = PH_DATA;
                        end
                        n_acc = '0;
                        n_cnt = '0;
                        n_bad = 1'b0;
                    end else if (r_phase == PH_EXT) begin
                        n_phase = PH_EXT;
                    end else if (i_item.is_semi) begin
                        n_phase = PH_EXT;
                    end else if (i_item.is_space) begin
                        if (r_phase == PH_DIGITS) begin
                            n_phase = PH_TRAILWS;
                        end
                    end else if (!i_item.is_hex || r_phase == PH_TRAILWS) begin
                        n_bad = 1'b1;
                    end else begin
                        n_phase = PH_DIGITS;
                        // A value above 0x0FFFFFFF cannot take one more digit
                        if (r_cnt >= MAX_CNT || (|r_acc[31:28])) begin
                            n_bad = 1'b1;
                        end else begin
                            n_acc = {r_acc[27:0], i_item.hex_val};
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                end
                PH_DATA: begin
                    n_out_valid = 1'b1;
                    n_out_byte  = i_item.data;
                    if (r_rem != '0) begin
                        n_rem = r_rem - 32'd1;
                    end
                    if (r_rem <= 32'd1) begin
                        n_phase = PH_TERM;
                    end
                end
                PH_TERM: begin
                    if (i_item.is_lf) begin
                        n_phase = PH_LEAD;
                    end else if (i_item.is_cr && !i_item.last) begin
                        n_phase = PH_TERM_CR;
                    end else begin
                        n_sticky = ST_NOTERM;
                    end
                end
                PH_TERM_CR: begin
                    if (i_item.is_lf) begin
                        n_phase = PH_LEAD;
                    end else begin
                        n_sticky = ST_NOTERM;
                    end
                end
                PH_ZERO_FIRST: begin
                    if (i_item.is_lf) begin
                        n_sticky = ST_DONE;
                    end else if (i_item.is_cr) begin
                        n_phase = PH_ZERO_FIRST_CR;
                    end else begin
                        n_tm    = TM_NONE;
                        n_phase = PH_ZERO_SCAN;
                    end
                end
                PH_ZERO_FIRST_CR: begin
                    if (i_item.is_lf) begin
                        n_sticky = ST_DONE;
                    end else begin
                        n_tm    = i_item.is_cr ? TM_CR : TM_NONE;
                        n_phase = PH_ZERO_SCAN;
                    end
                end
                PH_ZERO_SCAN, PH_ZERO_LF: begin
                    if (i_item.is_lf) begin
                        if (w_lf_done) begin
                            n_sticky = ST_DONE;
                        end else if (r_tm == TM_CR) begin
                            n_tm    = TM_CRLF;
                            n_phase = PH_ZERO_SCAN;
                        end else begin
                            n_tm    = TM_NONE;
                            n_phase = PH_ZERO_LF;
                        end
                    end else begin
                        if (i_item.is_cr) begin
                            n_tm = (r_phase == PH_ZERO_SCAN && r_tm == TM_CRLF) ?
                                   TM_CRLFCR : TM_CR;
                        end else begin
                            n_tm = TM_NONE;
                        end
                        n_phase = PH_ZERO_SCAN;
                    end
                end
                default: begin
                    n_phase = PH_LEAD;
                end
            endcase
        end

        n_status = n_sticky;
        if (i_item.last) begin
            if (n_sticky == ST_RUN) begin
                n_status = ST_SHORT;
            end
            // Re-arm for the next body
            n_phase  = PH_LEAD;
            n_sticky = ST_RUN;
            n_tm     = TM_NONE;
            n_acc    = '0;
            n_rem    = '0;
            n_cnt    = '0;
            n_bad    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEAD;
            r_sticky <= ST_RUN;
            r_tm     <= TM_NONE;
            r_acc    <= '0;
            r_rem    <= '0;
            r_cnt    <= '0;
            r_bad    <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            if (w_take) begin
                r_phase  <= n_phase;
                r_sticky <= n_sticky;
                r_tm     <= n_tm;
                r_acc    <= n_acc;
                r_rem    <= n_rem;
                r_cnt    <= n_cnt;
                r_bad    <= n_bad;
                r_valid  <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Hold the result register until the transaction completes
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_byte  <= n_out_byte;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
        end
    end

endmodule

### hw/rtl/http_chunked_body_decoder_unit.sv
// Channel | Valid   | Stall   | Payload
// --------+---------+---------+--------------------------------------------
// in      | i_valid | o_stall | i_data_byte[7:0], i_is_last
// out     | o_valid | i_stall | o_out_byte[7:0], o_out_valid, o_status[2:0]
//
// One byte per cycle sustained while the out channel does not stall; a byte is
// written into the queue at the accepting edge and then taken by the decode step
// into the result register, from which its result is valid.
// The rate is set by the decode step in the back part.
// i_rst_n is synchronous and returns the decoder to the start of a body.
// o_stall rises only when the QUEUE_DEPTH-entry queue is full, so up to
// QUEUE_DEPTH + 1 bytes are still taken while the out channel is stalled.
module http_chunked_body_decoder_unit
    import hcbd_pkg::*;
#(
    parameter int MAX_SIZE_DIGITS = DEF_MAX_SIZE_DIGITS,
    parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic [2:0] o_status
);

    t_item w_front_item;
    t_item w_queue_item;
    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_nempty;

    hcbd_front u_front (
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_is_last   (i_is_last),
        .i_full      (w_full),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_item      (w_front_item)
    );

    hcbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_front_item),
        .i_pop    (w_pop),
        .o_full   (w_full),
        .o_nempty (w_nempty),
        .o_item   (w_queue_item)
    );

    hcbd_back #(
        .MAX_SIZE_DIGITS (MAX_SIZE_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nempty    (w_nempty),
        .i_item      (w_queue_item),
        .o_pop       (w_pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_out_byte  (o_out_byte),
        .o_out_valid (o_out_valid),
        .o_status    (o_status)
    );

    // Payload only while the body is still open (or cut short on its last byte)
    a_payload_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_valid) |-> (o_status == ST_RUN || o_status == ST_SHORT))
        else $error("payload byte with a decided status");

    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_valid) |-> (o_out_byte == 8'h00))
        else $error("non-payload result carries a byte");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("result or stall present after reset");

    a_queue_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_nempty)
        else $error("back part took from an empty queue");

endmodule
